@@ src/lphm_pkg.sv @@
// lphm_pkg: shared sizes, request codes and the slot tag layout of the hash map
// no dependencies; compiled first
`timescale 1ns / 1ps

package lphm_pkg;

	localparam int SLOT_BITS  = 10;
	localparam int SLOT_COUNT = 1 << SLOT_BITS;
	localparam int KEY_W      = 64;
	localparam int VAL_W      = 64;
	localparam int FUNC_W     = 3;
	localparam int CNT_W      = 11;

	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(768);

	localparam logic [FUNC_W-1:0] FUNC_GET     = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_PUT     = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_REPLACE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd4;

	// key halves plus tombstone mark, one word of the tag memory
	typedef struct packed {
		logic             deleted;
		logic [KEY_W-1:0] key_high;
		logic [KEY_W-1:0] key_low;
	} slot_tag_t;

	localparam int TAG_W = $bits(slot_tag_t);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

endpackage

@@ src/lphm_if.sv @@
// lphm_req_if and lphm_rsp_if: valid/ready channels for requests and results
// depends on lphm_pkg for field widths
`timescale 1ns / 1ps

interface lphm_req_if;
	logic                           valid;
	logic                           ready;
	logic [lphm_pkg::FUNC_W-1:0]    func;
	logic [lphm_pkg::KEY_W-1:0]     key_low;
	logic [lphm_pkg::KEY_W-1:0]     key_high;
	logic [lphm_pkg::VAL_W-1:0]     new_value;

	modport source (output valid, func, key_low, key_high, new_value, input ready);
	modport sink (input valid, func, key_low, key_high, new_value, output ready);
endinterface

interface lphm_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           found;
	logic [lphm_pkg::VAL_W-1:0]     old_value;
	logic                           success;
	logic                           status;
	logic [lphm_pkg::CNT_W-1:0]     live_count;

	modport source (output valid, found, old_value, success, status, live_count, input ready);
	modport sink (input valid, found, old_value, success, status, live_count, output ready);
endinterface

@@ src/lphm_ram.sv @@
// lphm_ram: generic single-write, single-read synchronous ram, registered read data
// no dependencies
`timescale 1ns / 1ps

module lphm_ram #(
	parameter int WIDTH     = 64,
	parameter int ADDR_BITS = 10
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ src/linear_probe_hash_map_top.sv @@
// linear_probe_hash_map_top: open-addressed map with linear probing and tombstones
// depends on lphm_pkg, lphm_if (lphm_req_if, lphm_rsp_if) and lphm_ram
// a request runs ST_READ then ST_CHECK for each slot probed, then ST_DONE; a zero key or
//   unknown func goes straight to ST_CHECK; one item at a time, next item taken the cycle
//   after the result is loaded into the output register, which waits for rsp.ready
// each probe step is one tag/value memory read (ST_READ) plus one compare (ST_CHECK)
// reset: a clearing pass writes every tag slot, all 2^SLOT_BITS of them, no item taken
`timescale 1ns / 1ps

module linear_probe_hash_map_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [lphm_pkg::CNT_W-1:0]   cfg_wr_data,
	lphm_req_if.sink                     req,
	lphm_rsp_if.source                   rsp
);

	localparam logic [lphm_pkg::SLOT_BITS-1:0] LAST_STEP =
		lphm_pkg::SLOT_BITS'(lphm_pkg::SLOT_COUNT - 1);

	lphm_pkg::state_t state_q, state_d;

	logic [lphm_pkg::CNT_W-1:0]     limit_q;
	logic [lphm_pkg::CNT_W-1:0]     used_q;
	logic [lphm_pkg::CNT_W-1:0]     live_q;
	logic [lphm_pkg::SLOT_BITS:0]   clr_q;

	logic [lphm_pkg::FUNC_W-1:0]    func_q;
	logic [lphm_pkg::KEY_W-1:0]     key_low_q;
	logic [lphm_pkg::KEY_W-1:0]     key_high_q;
	logic [lphm_pkg::VAL_W-1:0]     new_value_q;
	logic                           skip_q;
	logic [lphm_pkg::SLOT_BITS-1:0] addr_q;
	logic [lphm_pkg::SLOT_BITS-1:0] step_q;

	// finished result waiting for the output register
	logic                           res_found_q;
	logic [lphm_pkg::VAL_W-1:0]     res_old_q;
	logic                           res_success_q;
	logic                           res_status_q;
	logic [lphm_pkg::CNT_W-1:0]     res_live_q;

	logic                           out_valid_q;
	logic                           out_found_q;
	logic [lphm_pkg::VAL_W-1:0]     out_old_q;
	logic                           out_success_q;
	logic                           out_status_q;
	logic [lphm_pkg::CNT_W-1:0]     out_live_q;

	logic                           accept;
	logic                           skip_in;
	logic                           clr_done;
	logic                           hit;
	logic                           empty;
	logic                           more;
	logic                           decide;
	logic                           live;
	logic                           out_load;

	lphm_pkg::slot_tag_t            tag_rd;
	lphm_pkg::slot_tag_t            tag_wdata;
	logic [lphm_pkg::TAG_W-1:0]     tag_rd_raw;
	logic                           tag_we;
	logic [lphm_pkg::SLOT_BITS-1:0] waddr;
	logic [lphm_pkg::VAL_W-1:0]     val_rd;
	logic                           val_we;

	logic                           used_inc;
	logic                           live_inc;
	logic                           live_dec;
	logic                           r_success;
	logic                           r_status;
	logic [lphm_pkg::CNT_W-1:0]     live_next;

	function automatic logic [lphm_pkg::CNT_W-1:0] CNT_W_ONE(input logic b);
		CNT_W_ONE = {{(lphm_pkg::CNT_W-1){1'b0}}, b};
	endfunction

	assign tag_rd = lphm_pkg::slot_tag_t'(tag_rd_raw);

	lphm_ram #(
		.WIDTH     (lphm_pkg::TAG_W),
		.ADDR_BITS (lphm_pkg::SLOT_BITS)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (waddr),
		.wdata (tag_wdata),
		.raddr (addr_q),
		.rdata (tag_rd_raw)
	);

	lphm_ram #(
		.WIDTH     (lphm_pkg::VAL_W),
		.ADDR_BITS (lphm_pkg::SLOT_BITS)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (addr_q),
		.wdata (new_value_q),
		.raddr (addr_q),
		.rdata (val_rd)
	);

	assign req.ready = (state_q == lphm_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign skip_in   = ((req.key_low == '0) && (req.key_high == '0)) ||
		!(req.func inside {lphm_pkg::FUNC_GET, lphm_pkg::FUNC_PUT, lphm_pkg::FUNC_REPLACE,
			lphm_pkg::FUNC_ADD, lphm_pkg::FUNC_REMOVE});
	assign clr_done  = (clr_q == (lphm_pkg::SLOT_BITS+1)'(lphm_pkg::SLOT_COUNT - 1));

	// probe outcome for the slot read in the previous cycle
	assign hit   = !skip_q && (tag_rd.key_low == key_low_q) && (tag_rd.key_high == key_high_q);
	assign empty = !skip_q && (tag_rd.key_low == '0) && (tag_rd.key_high == '0);
	assign more  = !skip_q && !hit && !empty && (step_q != LAST_STEP);
	assign decide = (state_q == lphm_pkg::ST_CHECK) && !more;
	assign live  = hit && !tag_rd.deleted;

	assign out_load = (state_q == lphm_pkg::ST_DONE) && (!out_valid_q || rsp.ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lphm_pkg::ST_CLEAR: begin
				if (clr_done) begin
					state_d = lphm_pkg::ST_IDLE;
				end
			end
			lphm_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = skip_in ? lphm_pkg::ST_CHECK : lphm_pkg::ST_READ;
				end
			end
			lphm_pkg::ST_READ: begin
				state_d = lphm_pkg::ST_CHECK;
			end
			lphm_pkg::ST_CHECK: begin
				state_d = more ? lphm_pkg::ST_READ : lphm_pkg::ST_DONE;
			end
			lphm_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = lphm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lphm_pkg::ST_IDLE;
			end
		endcase
	end

	// clearing writes, and memory writes and bookkeeping for the decision cycle
	always_comb begin
		tag_we    = 1'b0;
		val_we    = 1'b0;
		waddr     = addr_q;
		tag_wdata = '{deleted: 1'b0, key_high: key_high_q, key_low: key_low_q};
		used_inc  = 1'b0;
		live_inc  = 1'b0;
		live_dec  = 1'b0;
		r_success = 1'b0;
		r_status  = 1'b0;
		if (state_q == lphm_pkg::ST_CLEAR) begin
			tag_we    = 1'b1;
			waddr     = clr_q[lphm_pkg::SLOT_BITS-1:0];
			tag_wdata = '0;
		end else if (decide) begin
			case (func_q)
				lphm_pkg::FUNC_PUT, lphm_pkg::FUNC_ADD: begin
					if (hit) begin
						if (!live) begin
							// revive tombstone
							tag_we    = 1'b1;
							val_we    = 1'b1;
							live_inc  = 1'b1;
							r_success = (func_q == lphm_pkg::FUNC_ADD);
						end else if (func_q == lphm_pkg::FUNC_PUT) begin
							val_we = 1'b1;
						end
					end else if (empty && (used_q < limit_q)) begin
						tag_we    = 1'b1;
						val_we    = 1'b1;
						used_inc  = 1'b1;
						live_inc  = 1'b1;
						r_success = (func_q == lphm_pkg::FUNC_ADD);
					end else begin
						r_status = 1'b1;
					end
				end
				lphm_pkg::FUNC_REPLACE: begin
					val_we = live;
				end
				lphm_pkg::FUNC_REMOVE: begin
					if (live) begin
						tag_we    = 1'b1;
						tag_wdata = '{deleted: 1'b1, key_high: key_high_q, key_low: key_low_q};
						live_dec  = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign live_next = live_q + CNT_W_ONE(live_inc) - CNT_W_ONE(live_dec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lphm_pkg::ST_CLEAR;
			limit_q     <= lphm_pkg::LIMIT_RESET;
			used_q      <= '0;
			live_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (state_q == lphm_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (decide) begin
				used_q <= used_q + CNT_W_ONE(used_inc);
				live_q <= live_next;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q      <= req.func;
			key_low_q   <= req.key_low;
			key_high_q  <= req.key_high;
			new_value_q <= req.new_value;
			skip_q      <= skip_in;
			addr_q      <= req.key_low[lphm_pkg::SLOT_BITS-1:0];
			step_q      <= '0;
		end else if ((state_q == lphm_pkg::ST_CHECK) && more) begin
			addr_q <= addr_q + 1'b1;
			step_q <= step_q + 1'b1;
		end
		if (decide) begin
			res_found_q   <= live;
			res_old_q     <= live ? val_rd : '0;
			res_success_q <= r_success;
			res_status_q  <= r_status;
			res_live_q    <= live_next;
		end
		if (out_load) begin
			out_found_q   <= res_found_q;
			out_old_q     <= res_old_q;
			out_success_q <= res_success_q;
			out_status_q  <= res_status_q;
			out_live_q    <= res_live_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.found      = out_found_q;
	assign rsp.old_value  = out_old_q;
	assign rsp.success    = out_success_q;
	assign rsp.status     = out_status_q;
	assign rsp.live_count = out_live_q;

endmodule
